FILE: rtl/rsi_pkg.sv
// Shared types and constants for the rank sort block.
`default_nettype none

package rsi_pkg;

    // Fixed field widths
    localparam int KEY_W  = 31;
    localparam int RANK_W = 6;

    // Control of the shared compare and count unit
    typedef struct packed {
        logic clear;
        logic en;
    } rank_ctl_t;

endpackage : rsi_pkg

`default_nettype wire

FILE: rtl/rsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rsi_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : rsi_ram

`default_nettype wire

FILE: rtl/rsi_rank_unit.sv
// Shared comparator and rank counter: counts stored keys that order before the reference key.
`default_nettype none

module rsi_rank_unit #(
    parameter int IDX_W = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rsi_pkg::rank_ctl_t           ctl,
    input  wire logic [rsi_pkg::KEY_W-1:0]    key_ref,
    input  wire logic [IDX_W-1:0]             idx_ref,
    input  wire logic [rsi_pkg::KEY_W-1:0]    key_cand,
    input  wire logic [IDX_W-1:0]             idx_cand,
    output logic      [rsi_pkg::RANK_W-1:0]   rank
);

    import rsi_pkg::*;

    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              before_ref;

    // Order by key, then by load position on a tie
    assign before_ref = (key_cand < key_ref) ||
                        ((key_cand == key_ref) && (idx_cand < idx_ref));

    always_comb
    begin
        rank_next = rank_reg;
        if (ctl.clear)
        begin
            rank_next = '0;
        end
        else if (ctl.en && before_ref)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    // Hold the running count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    assign rank = rank_reg;

endmodule : rsi_rank_unit

`default_nettype wire

FILE: rtl/rank_sort_index_by_key.sv
// Top level of the rank sort: key store, sequencer and output beat register.
// Load: one key per cycle; the block is ready on every cycle while loading.
// Ranking: each result comes from one shared comparator scanning the store
//   through its single registered read port; no key is taken until the run ends.
// Reset clears count, overflow flag and sequencer; the key store is not cleared.
`default_nettype none

module rank_sort_index_by_key #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rsi_pkg::KEY_W-1:0]   key,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [rsi_pkg::RANK_W-1:0]  rank,
    output logic      [rsi_pkg::KEY_W-1:0]   key_out,
    output logic                             dropped,
    output logic                             end_of_run
);

    import rsi_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_CAPTURE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0]  key_ref_reg, key_ref_next;

    logic              in_beat;
    logic              out_beat;
    logic              has_room;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    logic              j_at_end;
    logic              i_at_end;
    rank_ctl_t         rank_ctl;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;
    assign has_room  = (count_reg < CNT_W'(MAX_KEYS));
    assign ram_we    = in_beat && has_room;
    assign ram_raddr = (state_reg == ST_FETCH) ? i_reg : j_reg;
    assign j_at_end  = ({{(CNT_W-IDX_W){1'b0}}, j_reg} == (n_reg - CNT_W'(1)));
    assign i_at_end  = ({{(CNT_W-IDX_W){1'b0}}, i_reg} == (n_reg - CNT_W'(1)));

    rsi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clear the count at the start of each key, count while scan data returns
    assign rank_ctl.clear = (state_reg == ST_CAPTURE);
    assign rank_ctl.en    = rd_pend_reg;

    rsi_rank_unit #(
        .IDX_W (IDX_W)
    ) u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rank_ctl),
        .key_ref  (key_ref_reg),
        .idx_ref  (i_reg),
        .key_cand (ram_rdata),
        .idx_cand (rd_idx_reg),
        .rank     (rank)
    );

    // Sequencer next-state logic
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        key_ref_next = key_ref_reg;
        rd_pend_next = (state_reg == ST_SCAN);
        rd_idx_next  = j_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next     = has_room ? (count_reg + CNT_W'(1)) : count_reg;
                        i_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE:
            begin
                key_ref_next = ram_rdata;
                j_next       = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_at_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    if (i_at_end)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            n_reg       <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        key_ref_reg <= key_ref_next;
    end

    assign key_out    = key_ref_reg;
    assign dropped    = ovf_reg;
    assign end_of_run = i_at_end;

    // The store never holds more keys than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count exceeds capacity");

    // A ranking run always covers at least one stored key
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (n_reg != '0) && (n_reg <= count_reg))
        else $error("ranking run with bad key total");

    // The key being ranked is one of the stored keys
    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({{(CNT_W-IDX_W){1'b0}}, i_reg} < n_reg))
        else $error("ranked position outside the run");

    // The final result beat returns the block to loading with a zero key count and no overflow
    a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && end_of_run |=> in_ready && (count_reg == '0) && !dropped)
        else $error("run did not close after final beat");

    // Rank of a key stays below the number of keys in its run
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({{(CNT_W-RANK_W){1'b0}}, rank} < n_reg))
        else $error("rank out of range");

endmodule : rank_sort_index_by_key

`default_nettype wire

FILE: bench/testbench.sv
// Testbench for rank_sort_index_by_key: key sets in, per-key ranks checked against a local ranker.
`timescale 1ns / 1ps

module testbench;

    import rsi_pkg::*;

    localparam int CAP       = 64;
    localparam int CALM_TAIL = 40;
    localparam int HOLD_LEN  = 400;
    localparam int DRAIN_CYC = 2 * (CAP + 4);
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
    } key_beat_t;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic [KEY_W-1:0]  key;
        logic              dropped;
        logic              eor;
    } ranked_key_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [KEY_W-1:0]    key        = '0;
    logic                last       = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [RANK_W-1:0]   rank;
    logic [KEY_W-1:0]    key_out;
    logic                dropped;
    logic                end_of_run;

    key_beat_t           key_beats_q[$];
    ranked_key_t         ranked_q[$];

    // Local copy of the key store and its bookkeeping
    logic [KEY_W-1:0]    key_store [CAP];
    int                  stored_n   = 0;
    logic                overflowed = 1'b0;

    int                  errors       = 0;
    int                  results_seen = 0;
    int                  in_gap       = 0;
    int                  out_gap      = 0;
    int                  hold_left    = 0;
    logic                hold_done    = 1'b0;

    rank_sort_index_by_key #(
        .MAX_KEYS (CAP)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key        (key),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rank       (rank),
        .key_out    (key_out),
        .dropped    (dropped),
        .end_of_run (end_of_run)
    );

    task automatic report(input string msg);
        $display("check failed at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Store one accepted key; on the closing beat rank every stored key
    task automatic store_and_rank(input logic [KEY_W-1:0] k, input logic lst);
        ranked_key_t r;
        int          pos;
        if (stored_n < CAP) begin
            key_store[stored_n] = k;
            stored_n++;
        end
        else begin
            overflowed = 1'b1;
        end
        if (lst) begin
            for (int i = 0; i < stored_n; i++) begin
                pos = 0;
                for (int j = 0; j < stored_n; j++) begin
                    if (key_store[j] < key_store[i] ||
                        (key_store[j] == key_store[i] && j < i))
                        pos++;
                end
                r.rank    = RANK_W'(pos);
                r.key     = key_store[i];
                r.dropped = overflowed;
                r.eor     = (i == stored_n - 1);
                ranked_q.push_back(r);
            end
            stored_n   = 0;
            overflowed = 1'b0;
        end
    endtask

    task automatic add_beat(input logic [KEY_W-1:0] k, input logic lst);
        key_beat_t b;
        b.key  = k;
        b.last = lst;
        key_beats_q.push_back(b);
    endtask

    // Mix of full-range keys, a narrow range for ties, and the extremes
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return KEY_W'($urandom());
        else if (sel < 8)
            return KEY_W'($urandom_range(0, 7));
        else
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return KEY_MAX;
                2:       return KEY_MAX - 1;
                default: return KEY_W'(1);
            endcase
    endfunction

    task automatic add_set(input int size);
        for (int i = 0; i < size; i++)
            add_beat(pick_key(), i == size - 1);
    endtask

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sender: offer queued beats, with random idle bursts outside the tail
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            key      <= '0;
            last     <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                store_and_rank(key, last);
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (key_beats_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    key      <= key_beats_q[0].key;
                    last     <= key_beats_q[0].last;
                    void'(key_beats_q.pop_front());
                    if (key_beats_q.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
                        in_gap <= $urandom_range(1, 5);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off mid-run, plus random stall bursts outside the tail
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 40)
        begin
            hold_left <= HOLD_LEN - 1;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap   <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else if (key_beats_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
        begin
            out_gap   <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compare each result beat with the oldest pending rank
    always @(posedge clk)
    begin : monitor
        ranked_key_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (ranked_q.size() == 0)
            begin
                report($sformatf("unexpected result: rank %0d key %0h", rank, key_out));
            end
            else
            begin
                want = ranked_q.pop_front();
                if (rank !== want.rank)
                    report($sformatf("key %0h: rank %0d, want %0d", want.key, rank, want.rank));
                if (key_out !== want.key)
                    report($sformatf("key_out %0h, want %0h", key_out, want.key));
                if (dropped !== want.dropped)
                    report($sformatf("key %0h: dropped %0b, want %0b",
                                     want.key, dropped, want.dropped));
                if (end_of_run !== want.eor)
                    report($sformatf("key %0h: end_of_run %0b, want %0b",
                                     want.key, end_of_run, want.eor));
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int random_items;

        // Single-key set at the top of the range
        add_beat(KEY_MAX, 1'b1);
        // Extremes and ties
        add_beat('0, 1'b0);
        add_beat(KEY_MAX, 1'b0);
        add_beat('0, 1'b0);
        add_beat(KEY_MAX, 1'b0);
        add_beat(KEY_W'(1) << (KEY_W - 1), 1'b0);
        add_beat(KEY_W'(5), 1'b0);
        add_beat(KEY_W'(5), 1'b1);
        // Descending keys
        for (int i = 7; i >= 3; i--)
            add_beat(KEY_W'(i), i == 3);
        // Alternating bit patterns
        add_beat(31'h2AAA_AAAA, 1'b0);
        add_beat(31'h5555_5555, 1'b1);

        // Exactly full store, then overflow with the closing key dropped
        add_set(CAP);
        add_set(CAP + 3);
        random_items = 2 * CAP + 3;
        while (random_items < 370)
        begin
            int size;
            if ($urandom_range(0, 11) == 0)
                size = $urandom_range(CAP - 2, CAP + 4);
            else
                size = $urandom_range(1, 12);
            add_set(size);
            random_items += size;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (key_beats_q.size() != 0 || in_valid)
            @(posedge clk);
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
